/* rtl/plnrle_pkg.sv */
// ----------------------------------------------------------------------------
// plnrle_pkg
// shared widths, register indexes, sequencer states, handshake structs and
// symbol helpers for the planar nibble run-length decoder
// ----------------------------------------------------------------------------
package plnrle_pkg;

  localparam int WORD_W              = 32;
  localparam int NB_W                = 3;
  localparam int MASK_W              = 16;
  localparam int TOTAL_W             = 21;
  localparam int CFG_DATA_W          = 21;
  localparam int CFG_IDX_W           = 2;
  localparam int SYM_W               = 4;
  localparam int BYTE_W              = 8;
  localparam int DEF_MAX_PIXELS_LOG2 = 20;
  localparam int STEP_LIMIT          = 64;
  localparam int STEP_W              = 7;
  localparam int K_W                 = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RUN_MASK      = 2'd0,
    REG_PIXEL_TOTAL   = 2'd1,
    REG_LITTLE_ENDIAN = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_SYM,
    SEQ_CNT,
    SEQ_RUN,
    SEQ_END,
    SEQ_FILL
  } seq_state_t;

  typedef struct packed {
    logic             go;
    logic [SYM_W-1:0] colour;
  } pix_req_t;

  typedef struct packed {
    logic taken;
    logic emit;
    logic finish;
    logic done;
  } pix_stat_t;

  // symbol k: bit 7-k of each byte, low byte gives the high symbol bit
  function automatic logic [SYM_W-1:0] symbol_at(input logic [WORD_W-1:0] w,
                                                 input logic [2:0] k);
    logic [7:0] b0, b1, b2, b3;
    logic [2:0] idx;
    b0  = w[7:0];
    b1  = w[15:8];
    b2  = w[23:16];
    b3  = w[31:24];
    idx = 3'd7 - k;
    return {b0[idx], b1[idx], b2[idx], b3[idx]};
  endfunction

  // drop bytes past the valid count, then apply byte order
  function automatic logic [WORD_W-1:0] prep_word(input logic [WORD_W-1:0] raw,
                                                  input logic [NB_W-1:0] nb,
                                                  input logic le);
    logic [WORD_W-1:0] keep;
    logic [WORD_W-1:0] w;
    unique case (nb)
      3'd0:    keep = 32'h0000_0000;
      3'd1:    keep = 32'hFF00_0000;
      3'd2:    keep = 32'hFFFF_0000;
      3'd3:    keep = 32'hFFFF_FF00;
      default: keep = 32'hFFFF_FFFF;
    endcase
    w = raw & keep;
    if (le) begin
      w = {w[7:0], w[15:8], w[23:16], w[31:24]};
    end
    return w;
  endfunction

endpackage

/* rtl/plnrle_in_if.sv */
// ----------------------------------------------------------------------------
// plnrle_in_if
// input channel: data words or end-of-data marks with valid/ready
// ----------------------------------------------------------------------------
interface plnrle_in_if;
  import plnrle_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [WORD_W-1:0] data_word;
  logic [NB_W-1:0]   bytes_valid;

  modport source (output valid, output kind, output data_word, output bytes_valid,
                  input ready);
  modport sink (input valid, input kind, input data_word, input bytes_valid,
                output ready);
endinterface

/* rtl/plnrle_out_if.sv */
// ----------------------------------------------------------------------------
// plnrle_out_if
// output channel: packed pixel bytes with valid/ready
// ----------------------------------------------------------------------------
interface plnrle_out_if;
  import plnrle_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] packed_byte;
  logic              last;

  modport source (output valid, output packed_byte, output last, input ready);
  modport sink (input valid, input packed_byte, input last, output ready);
endinterface

/* rtl/plnrle_pixel_unit.sv */
// ----------------------------------------------------------------------------
// plnrle_pixel_unit
// shared pixel path: packs one pixel per cycle into bytes while its output
// byte register is free, counts down the image length and holds that register
// ----------------------------------------------------------------------------
module plnrle_pixel_unit #(
  parameter int MAX_PIXELS_LOG2 = plnrle_pkg::DEF_MAX_PIXELS_LOG2
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              restart,
  input  logic [plnrle_pkg::TOTAL_W-1:0]    pixel_total,
  input  plnrle_pkg::pix_req_t              req,
  output plnrle_pkg::pix_stat_t             stat,
  plnrle_out_if.source                      dout
);
  import plnrle_pkg::*;

  localparam int PL_W  = MAX_PIXELS_LOG2 + 1;
  localparam int CMP_W = (PL_W > TOTAL_W) ? PL_W : TOTAL_W;

  logic [SYM_W-1:0]  held;
  logic              half;
  logic [PL_W-1:0]   pixels_left;
  logic              image_done;
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;

  logic [CMP_W-1:0]  total_ext;
  logic [CMP_W-1:0]  limit;
  logic [PL_W-1:0]   start_len;
  logic              fin;
  logic              will_emit;
  logic              slot_free;
  logic              taken;

  always_comb begin
    total_ext = CMP_W'(pixel_total);
    limit     = CMP_W'(1) << MAX_PIXELS_LOG2;
    start_len = (total_ext > limit) ? PL_W'(limit) : PL_W'(total_ext);
    fin       = (pixels_left == PL_W'(1));
    will_emit = half | fin;
    slot_free = !out_valid | dout.ready;
    taken     = req.go & !image_done & (!will_emit | slot_free);
  end

  assign stat.taken  = taken;
  assign stat.emit   = taken & will_emit;
  assign stat.finish = taken & fin;
  assign stat.done   = image_done;

  assign dout.valid       = out_valid;
  assign dout.packed_byte = out_byte;
  assign dout.last        = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      held        <= '0;
      half        <= 1'b0;
      pixels_left <= PL_W'(1);
      image_done  <= 1'b0;
      out_valid   <= 1'b0;
    end else if (restart) begin
      held        <= '0;
      half        <= 1'b0;
      pixels_left <= start_len;
      image_done  <= (start_len == '0);
      out_valid   <= 1'b0;
    end else begin
      if (taken) begin
        if (half) begin
          half <= 1'b0;
        end else begin
          held <= req.colour;
          half <= !fin;
        end
        pixels_left <= pixels_left - PL_W'(1);
        if (fin) begin
          image_done <= 1'b1;
        end
      end
      if (taken && will_emit) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (taken && will_emit) begin
      out_byte <= half ? {held, req.colour} : {req.colour, 4'h0};
      out_last <= fin;
    end
  end

endmodule

/* rtl/plnrle_seq.sv */
// ----------------------------------------------------------------------------
// plnrle_seq
// symbol sequencer: walks the eight planar symbols of a word, loads repeat
// counts and drives runs and end-of-data fill into the pixel unit
// ----------------------------------------------------------------------------
module plnrle_seq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           restart,
  input  logic [plnrle_pkg::MASK_W-1:0]  run_mask,
  input  logic                           little_endian,
  input  plnrle_pkg::pix_stat_t          stat,
  output plnrle_pkg::pix_req_t           req,
  plnrle_in_if.sink                      din
);
  import plnrle_pkg::*;

  seq_state_t        state, state_next;
  logic [WORD_W-1:0] word, word_next;
  logic              partial, partial_next;
  logic [K_W-1:0]    k, k_next;
  logic [SYM_W-1:0]  reps, reps_next;
  logic [SYM_W-1:0]  colour, colour_next;
  logic              fill_mode, fill_mode_next;
  logic              count_pending, count_pending_next;
  logic [STEP_W-1:0] step_cnt, step_cnt_next;

  logic [SYM_W-1:0]  sym;
  logic [NB_W-1:0]   nb;
  logic [STEP_W-1:0] step_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= SEQ_IDLE;
      partial       <= 1'b0;
      k             <= '0;
      reps          <= '0;
      colour        <= '0;
      fill_mode     <= 1'b0;
      count_pending <= 1'b0;
      step_cnt      <= '0;
    end else begin
      state         <= state_next;
      partial       <= partial_next;
      k             <= k_next;
      reps          <= reps_next;
      colour        <= colour_next;
      fill_mode     <= fill_mode_next;
      count_pending <= count_pending_next;
      step_cnt      <= step_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

  always_comb begin
    sym      = symbol_at(word, k[2:0]);
    nb       = (din.bytes_valid > NB_W'(4)) ? NB_W'(4) : din.bytes_valid;
    step_inc = step_cnt + STEP_W'(stat.emit);

    state_next         = state;
    word_next          = word;
    partial_next       = partial;
    k_next             = k;
    reps_next          = reps;
    colour_next        = colour;
    fill_mode_next     = fill_mode;
    count_pending_next = count_pending;
    step_cnt_next      = step_cnt;
    req.go             = 1'b0;
    req.colour         = colour;
    din.ready          = (state == SEQ_IDLE);

    unique case (state)
      SEQ_IDLE: begin
        if (din.valid && !stat.done) begin
          step_cnt_next = '0;
          if (fill_mode) begin
            state_next = SEQ_FILL;
          end else if (din.kind || nb == '0 || (count_pending && nb != NB_W'(4))) begin
            fill_mode_next     = 1'b1;
            count_pending_next = 1'b0;
            state_next         = SEQ_FILL;
          end else begin
            word_next    = prep_word(din.data_word, nb, little_endian);
            partial_next = (nb != NB_W'(4));
            k_next       = '0;
            if (count_pending) begin
              count_pending_next = 1'b0;
              state_next         = SEQ_CNT;
            end else begin
              state_next = SEQ_SYM;
            end
          end
        end
      end
      SEQ_SYM: begin
        req.go     = 1'b1;
        req.colour = sym;
        if (stat.taken) begin
          colour_next   = sym;
          step_cnt_next = step_inc;
          if (stat.finish) begin
            fill_mode_next     = 1'b0;
            count_pending_next = 1'b0;
            state_next         = SEQ_IDLE;
          end else if (run_mask[sym]) begin
            if (k[2:0] == 3'd7) begin
              if (!partial) begin
                count_pending_next = 1'b1;
              end
              state_next = SEQ_END;
            end else begin
              k_next     = k + K_W'(1);
              state_next = SEQ_CNT;
            end
          end else if (k[2:0] == 3'd7) begin
            state_next = SEQ_END;
          end else begin
            k_next = k + K_W'(1);
          end
        end
      end
      SEQ_CNT: begin
        reps_next  = sym;
        k_next     = k + K_W'(1);
        state_next = SEQ_RUN;
      end
      SEQ_RUN: begin
        if (reps == '0) begin
          state_next = k[3] ? SEQ_END : SEQ_SYM;
        end else begin
          req.go = 1'b1;
          if (stat.taken) begin
            reps_next     = reps - SYM_W'(1);
            step_cnt_next = step_inc;
            if (stat.finish) begin
              fill_mode_next     = 1'b0;
              count_pending_next = 1'b0;
              state_next         = SEQ_IDLE;
            end
          end
        end
      end
      SEQ_END: begin
        if (partial) begin
          fill_mode_next     = 1'b1;
          count_pending_next = 1'b0;
          state_next         = SEQ_FILL;
        end else begin
          state_next = SEQ_IDLE;
        end
      end
      SEQ_FILL: begin
        if (step_cnt == STEP_W'(STEP_LIMIT)) begin
          state_next = SEQ_IDLE;
        end else begin
          req.go = 1'b1;
          if (stat.taken) begin
            step_cnt_next = step_inc;
            if (stat.finish) begin
              fill_mode_next = 1'b0;
              state_next     = SEQ_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = SEQ_IDLE;
      end
    endcase

    // new image
    if (restart) begin
      colour_next        = '0;
      fill_mode_next     = 1'b0;
      count_pending_next = 1'b0;
    end
  end

endmodule

/* rtl/planar_nibble_rle_decoder.sv */
// ----------------------------------------------------------------------------
// planar_nibble_rle_decoder
// decodes 4-bit planar run-length coded words into packed pixel bytes
// ----------------------------------------------------------------------------
// One pixel path serves the whole block and places one pixel per cycle while
// its output register is free. A data word is accepted, then each symbol is
// placed, each repeat count is loaded, the repeated pixels are placed, the run
// is left, and the word is closed; an end-of-data item or a fill continuation
// is accepted and then places fill pixels, up to 128 pixels (64 words) per
// item, and stops at that limit. A partial word runs on into fill within the
// same item. The input is not ready while a word is being worked on, and a
// full output register that is not taken holds the pixel path. Writing
// pixel_total starts a new image at that same clock edge.
module planar_nibble_rle_decoder #(
  parameter int MAX_PIXELS_LOG2 = plnrle_pkg::DEF_MAX_PIXELS_LOG2
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [plnrle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [plnrle_pkg::CFG_DATA_W-1:0] cfg_data,
  plnrle_in_if.sink                         din,
  plnrle_out_if.source                      dout
);
  import plnrle_pkg::*;

  logic [MASK_W-1:0]  run_mask;
  logic               little_endian;
  logic               restart;
  pix_req_t           req;
  pix_stat_t          stat;

  assign restart = cfg_we && (cfg_index == REG_PIXEL_TOTAL);

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mask      <= '0;
      little_endian <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RUN_MASK:      run_mask      <= cfg_data[MASK_W-1:0];
          REG_LITTLE_ENDIAN: little_endian <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  plnrle_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .restart       (restart),
    .run_mask      (run_mask),
    .little_endian (little_endian),
    .stat          (stat),
    .req           (req),
    .din           (din)
  );

  plnrle_pixel_unit #(
    .MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2)
  ) u_pixel (
    .clk         (clk),
    .rst         (rst),
    .restart     (restart),
    .pixel_total (cfg_data[TOTAL_W-1:0]),
    .req         (req),
    .stat        (stat),
    .dout        (dout)
  );

  // no pixel requested once the image is complete
  a_no_pixel_after_done: assert property (@(posedge clk) disable iff (rst)
    !(req.go && stat.done))
    else $error("pixel requested after image end");

  // nothing follows the final word of an image
  a_quiet_after_last: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && dout.ready && dout.last) |=> !dout.valid)
    else $error("word after final word");

  // an idle sequencer issues no pixels
  a_idle_no_pixel: assert property (@(posedge clk) disable iff (rst)
    din.ready |-> !req.go)
    else $error("pixel issued while idle");

endmodule
